// ----- sv/iorw_pkg.sv -----
// ----------------------------------------------------------------------------
// iorw_pkg
// Shared constants, codes and item types of the in-order reorder window.
// ----------------------------------------------------------------------------
package iorw_pkg;

   // window size and derived widths
   localparam int SLOTS      = 16;
   localparam int SLOT_LOG   = $clog2(SLOTS);
   localparam int SLOT_W     = (SLOTS > 1) ? SLOT_LOG : 1;

   // most delivered items per accepted command
   localparam int DRAIN_MAX  = 16;
   localparam int CNT_W      = $clog2(DRAIN_MAX + 1);

   // slot = index mod SLOTS via a reciprocal multiply and one correction
   localparam int RECIP_SHIFT = 32 + SLOT_LOG;
   localparam int PROD_W      = 65;
   localparam logic [32:0] RECIP = 33'((64'd1 << RECIP_SHIFT) / SLOTS);

   // queue depths
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_AW    = $clog2(RSPQ_DEPTH);

   // command codes
   localparam logic [1:0] CMD_PUBLISH   = 2'd0;
   localparam logic [1:0] CMD_SET_TOTAL = 2'd1;
   localparam logic [1:0] CMD_ABORT     = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_DELIVERED = 2'd0;
   localparam logic [1:0] STAT_RETRY     = 2'd1;
   localparam logic [1:0] STAT_END       = 2'd2;
   localparam logic [1:0] STAT_ABORTED   = 2'd3;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0]        cmd;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       index;
      logic [63:0]       payload;
      logic [31:0]       total_count;
   } iorw_cmd_type;

   // result item
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_index;
      logic [63:0] out_payload;
      logic        last;
   } iorw_rsp_type;

endpackage

// ----- sv/iorw_front.sv -----
// ----------------------------------------------------------------------------
// iorw_front
// Accepts items, works out the slot of each index and queues the classified
// commands for the back end.
// ----------------------------------------------------------------------------
module iorw_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [1:0]             req_cmd,
   input  logic [31:0]            req_index,
   input  logic [63:0]            req_payload,
   input  logic [31:0]            req_total_count,
   output logic                   cmd_valid,
   output iorw_pkg::iorw_cmd_type cmd,
   input  logic                   cmd_take
);
   import iorw_pkg::*;

   localparam int QW = PROD_W - RECIP_SHIFT;

   logic                s1_valid_ff, s1_valid_in;
   logic [1:0]          s1_cmd_ff;
   logic [31:0]         s1_index_ff;
   logic [63:0]         s1_payload_ff;
   logic [31:0]         s1_total_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                accept;

   logic [QW-1:0]       quot;
   logic [31:0]         quot_s;
   logic [31:0]         rem;
   logic [31:0]         rem_fix;
   iorw_cmd_type        entry;

   iorw_cmd_type        q_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]    count_ff, count_in;
   logic                take;

   // accept while queue plus the stage in flight has room
   assign full   = ({1'b0, count_ff} + (CMDQ_AW + 1)'(s1_valid_ff))
                   >= (CMDQ_AW + 1)'(CMDQ_DEPTH);
   assign accept = push && !full;
   assign s1_valid_in = accept;

   // first stage: capture item and the reciprocal product
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_cmd_ff     <= req_cmd;
         s1_index_ff   <= req_index;
         s1_payload_ff <= req_payload;
         s1_total_ff   <= req_total_count;
         prod_ff       <= PROD_W'(req_index) * PROD_W'(RECIP);
      end
   end

   // second stage: remainder with one correction step
   always_comb begin
      quot    = prod_ff[PROD_W-1:RECIP_SHIFT];
      quot_s  = 32'(quot) * 32'(SLOTS);
      rem     = s1_index_ff - quot_s;
      rem_fix = (rem >= 32'(SLOTS)) ? (rem - 32'(SLOTS)) : rem;
      entry.cmd         = s1_cmd_ff;
      entry.slot        = rem_fix[SLOT_W-1:0];
      entry.index       = s1_index_ff;
      entry.payload     = s1_payload_ff;
      entry.total_count = s1_total_ff;
   end

   // command queue pointers and fill count
   assign take = cmd_take && cmd_valid;
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (s1_valid_ff) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (CMDQ_AW + 1)'(s1_valid_ff) - (CMDQ_AW + 1)'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   // queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (CMDQ_AW + 1)'(CMDQ_DEPTH))
      else $error("command queue overflow");

endmodule

// ----- sv/iorw_back.sv -----
// ----------------------------------------------------------------------------
// iorw_back
// Window state and drain sequencer: stores published items, walks ready
// entries at the head and produces result items in index order.
// ----------------------------------------------------------------------------
module iorw_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  iorw_pkg::iorw_cmd_type cmd,
   output logic                   cmd_take,
   output logic                   rsp_push,
   output iorw_pkg::iorw_rsp_type rsp,
   input  logic                   rsp_full
);
   import iorw_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;
   localparam logic [1:0] S_END  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [31:0]       head_ff, head_in;
   logic [SLOT_W-1:0] head_slot_ff, head_slot_in;
   logic [31:0]       total_ff, total_in;
   logic              known_ff, known_in;
   logic              aborted_ff, aborted_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOTS-1:0]  ready_ff, ready_in;

   logic [63:0]       slot_mem [SLOTS];
   logic [63:0]       rd_payload_ff;
   logic              mem_we;

   logic              at_end;
   logic [31:0]       head_inc;
   logic              next_at_end;
   logic [SLOT_W-1:0] slot_inc;
   logic              ready_next;
   logic              more;
   logic              outside;

   // window and drain conditions
   always_comb begin
      at_end      = known_ff && (head_ff >= total_ff);
      head_inc    = head_ff + 32'd1;
      next_at_end = known_ff && (head_inc >= total_ff);
      slot_inc    = (head_slot_ff == SLOT_W'(SLOTS - 1)) ? '0 : head_slot_ff + 1'b1;
      ready_next  = ready_ff[slot_inc] && (slot_inc != head_slot_ff);
      more        = (CNT_W'(cnt_ff + 1'b1) < CNT_W'(DRAIN_MAX)) && !next_at_end
                    && ready_next;
      outside     = {1'b0, cmd.index} >= ({1'b0, head_ff} + 33'(SLOTS));
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      head_slot_in = head_slot_ff;
      total_in     = total_ff;
      known_in     = known_ff;
      aborted_in   = aborted_ff;
      cnt_in       = cnt_ff;
      ready_in     = ready_ff;
      mem_we       = 1'b0;
      cmd_take     = 1'b0;
      rsp_push     = 1'b0;
      rsp          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (aborted_ff || cmd.cmd == CMD_ABORT) begin
                  if (!rsp_full) begin
                     rsp_push       = 1'b1;
                     rsp.status     = STAT_ABORTED;
                     rsp.last       = 1'b1;
                     aborted_in     = 1'b1;
                     cmd_take       = 1'b1;
                  end
               end else if (cmd.cmd == CMD_PUBLISH) begin
                  if (outside) begin
                     if (!rsp_full) begin
                        rsp_push      = 1'b1;
                        rsp.status    = STAT_RETRY;
                        rsp.out_index = cmd.index;
                        rsp.last      = 1'b1;
                        cmd_take      = 1'b1;
                     end
                  end else begin
                     mem_we              = 1'b1;
                     ready_in[cmd.slot]  = 1'b1;
                     cmd_take            = 1'b1;
                     cnt_in              = '0;
                     state_in            = S_READ;
                  end
               end else if (cmd.cmd == CMD_SET_TOTAL) begin
                  total_in = cmd.total_count;
                  known_in = 1'b1;
                  cmd_take = 1'b1;
                  cnt_in   = '0;
                  state_in = S_READ;
               end else begin
                  cmd_take = 1'b1;
               end
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!at_end && ready_ff[head_slot_ff]) begin
               if (!rsp_full) begin
                  rsp_push               = 1'b1;
                  rsp.status             = STAT_DELIVERED;
                  rsp.out_index          = head_ff;
                  rsp.out_payload        = rd_payload_ff;
                  rsp.last               = !more && !next_at_end;
                  ready_in[head_slot_ff] = 1'b0;
                  head_in                = head_inc;
                  head_slot_in           = slot_inc;
                  cnt_in                 = cnt_ff + 1'b1;
                  state_in = more ? S_READ : (next_at_end ? S_END : S_IDLE);
               end
            end else if (at_end) begin
               if (!rsp_full) begin
                  rsp_push      = 1'b1;
                  rsp.status    = STAT_END;
                  rsp.out_index = head_ff;
                  rsp.last      = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_END: begin
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               rsp.status    = STAT_END;
               rsp.out_index = head_ff;
               rsp.last      = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         head_slot_ff <= '0;
         total_ff     <= '0;
         known_ff     <= 1'b0;
         aborted_ff   <= 1'b0;
         cnt_ff       <= '0;
         ready_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         head_slot_ff <= head_slot_in;
         total_ff     <= total_in;
         known_ff     <= known_in;
         aborted_ff   <= aborted_in;
         cnt_ff       <= cnt_in;
         ready_ff     <= ready_in;
      end
   end

   // payload memory, registered read at the head slot
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[cmd.slot] <= cmd.payload;
      end
      rd_payload_ff <= slot_mem[head_slot_ff];
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> (cmd_valid && state_ff == S_IDLE))
      else $error("command taken outside idle");

   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (cnt_ff < CNT_W'(DRAIN_MAX)))
      else $error("drain ran past its limit");

   a_abort_sticky: assert property (@(posedge clock) disable iff (reset)
      aborted_ff |=> aborted_ff)
      else $error("abort flag cleared");

   a_clear_delivered: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp.status == STAT_DELIVERED) |=> !ready_ff[$past(head_slot_ff)])
      else $error("delivered slot still marked ready");

endmodule

// ----- sv/iorw_rspq.sv -----
// ----------------------------------------------------------------------------
// iorw_rspq
// Result queue: holds finished result items until the consumer pops them.
// ----------------------------------------------------------------------------
module iorw_rspq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_push,
   input  iorw_pkg::iorw_rsp_type wr_item,
   output logic                   wr_full,
   input  logic                   pop,
   output logic                   empty,
   output iorw_pkg::iorw_rsp_type rd_item
);
   import iorw_pkg::*;

   iorw_rsp_type       q_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_AW:0]   count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   assign wr_full = (count_ff == (RSPQ_AW + 1)'(RSPQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_push && !wr_full;
   assign do_rd   = pop && !empty;
   assign rd_item = q_ff[rd_ptr_ff];

   // pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == RSPQ_AW'(RSPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == RSPQ_AW'(RSPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (RSPQ_AW + 1)'(do_wr) - (RSPQ_AW + 1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ----- sv/in_order_reorder_window.sv -----
// ----------------------------------------------------------------------------
// in_order_reorder_window
// Reorder window: published items come back out in index order.
// Path: front stage and command queue, then the engine and the result queue.
// Throughput: front takes an item a cycle while not full; the engine answers
// a retry, abort or unused command from idle, takes a publish or set total
// through its read and emit states, and reads then emits each delivered item
// (then any end result), since the payload memory read is registered.
// Reset: synchronous; clears ready bits, head, total, abort flag and queues.
// ----------------------------------------------------------------------------
module in_order_reorder_window (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_index,
   input  logic [63:0] req_payload,
   input  logic [31:0] req_total_count,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_index,
   output logic [63:0] rsp_out_payload,
   output logic        rsp_last
);
   import iorw_pkg::*;

   logic         cmd_valid;
   iorw_cmd_type cmd;
   logic         cmd_take;
   logic         rsp_push;
   iorw_rsp_type rsp_item;
   logic         rsp_full;
   iorw_rsp_type out_item;

   // intake and slot classification
   iorw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_cmd         (req_cmd),
      .req_index       (req_index),
      .req_payload     (req_payload),
      .req_total_count (req_total_count),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take)
   );

   // window state and drain
   iorw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_push  (rsp_push),
      .rsp       (rsp_item),
      .rsp_full  (rsp_full)
   );

   // result queue
   iorw_rspq u_rspq (
      .clock   (clock),
      .reset   (reset),
      .wr_push (rsp_push),
      .wr_item (rsp_item),
      .wr_full (rsp_full),
      .pop     (pop),
      .empty   (empty),
      .rd_item (out_item)
   );

   assign rsp_status      = out_item.status;
   assign rsp_out_index   = out_item.out_index;
   assign rsp_out_payload = out_item.out_payload;
   assign rsp_last        = out_item.last;

endmodule
